FILE: rtl/core/ibu_pkg.sv
// Shared constants and the reciprocal table for the bitmap integer upscaler.
`timescale 1ns / 1ps

package ibu_pkg;

  localparam int IMAGE_SIDE  = 64;
  localparam int MAX_SCALE   = 16;
  localparam int WORD_BITS   = 16;
  localparam int SRC_WORDS   = IMAGE_SIDE * IMAGE_SIDE / WORD_BITS;
  localparam int ADDR_W      = $clog2(SRC_WORDS);
  localparam int SCALE_W     = 5;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int LIMIT_W     = 17;

  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // ceil(2^19 / f): floor(x * r >> 19) equals x / f for x * f below 2^19.
  function automatic recip_t recip_of(input scale_t f);
    recip_t r;
    case (f)
      5'd1:    r = 20'd524288;
      5'd2:    r = 20'd262144;
      5'd3:    r = 20'd174763;
      5'd4:    r = 20'd131072;
      5'd5:    r = 20'd104858;
      5'd6:    r = 20'd87382;
      5'd7:    r = 20'd74899;
      5'd8:    r = 20'd65536;
      5'd9:    r = 20'd58255;
      5'd10:   r = 20'd52429;
      5'd11:   r = 20'd47663;
      5'd12:   r = 20'd43691;
      5'd13:   r = 20'd40330;
      5'd14:   r = 20'd37450;
      5'd15:   r = 20'd34953;
      5'd16:   r = 20'd32768;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/ibu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ibu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bitmap_integer_upscaler.sv
// Top level of the bitmap integer upscaler: index pipeline, source RAM, output skid.
//
// Usage:
//   Input stream (s_*): s_tuser is the request kind (0 load, 1 read); s_tdata
//   carries word_index in [15:0] and load_data in [31:16]. A load writes one
//   16-bit source word of the 64x64 one-bit image (index 256 and up is
//   dropped) and returns nothing. A read returns one 16-bit word of the image
//   enlarged by scale_factor through pixel replication.
//   Output stream (m_*): m_tdata is the enlarged word, m_tuser flags an index
//   past the enlarged image (then the word is zero).
//   Configuration: cfg_we writes cfg_wdata into scale_factor; write it only
//   while no request is in flight, a request may follow on the next cycle.
//   Factors above 16 act as 16, zero makes every read out of range.
// Throughput: one request per cycle while s_tready is high; each request passes the
//   two shared RAM copies once, so there is no repeat cycle. A read result passes
//   stages 1 to 5 and then the output register before it shows on m_tvalid.
// Reset: rst clears all valid flags and sets scale_factor to 1; the source
//   image holds garbage until loaded.
// Stall: a two-entry output stage (main plus skid) absorbs one extra result;
//   when the skid fills, the whole pipeline holds and s_tready drops.
`timescale 1ns / 1ps

module bitmap_integer_upscaler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // word_index[15:0], load_data[31:16]
  input  logic                        s_tuser,   // kind
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // pixel_word[15:0]
  output logic                        m_tuser,   // out_of_range
  input  logic                        cfg_we,
  input  logic [ibu_pkg::SCALE_W-1:0] cfg_wdata
);

  import ibu_pkg::*;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  // Saturated factor and the values derived from it, loaded on a write.
  scale_t             f_sat;
  recip_t             recip;
  logic [LIMIT_W-1:0] limit;
  scale_t             cfg_sat;
  logic [9:0]         cfg_sq;

  assign cfg_sat = (cfg_wdata > scale_t'(MAX_SCALE)) ? scale_t'(MAX_SCALE) : cfg_wdata;
  assign cfg_sq  = {5'd0, cfg_sat} * {5'd0, cfg_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_sat <= scale_t'(1);
      recip <= recip_of(scale_t'(1));
      limit <= LIMIT_W'(256);
    end else if (cfg_we) begin
      // Saturate the factor, then look up its reciprocal and the read limit.
      f_sat <= cfg_sat;
      recip <= recip_of(cfg_sat);
      limit <= {cfg_sq[8:0], 8'd0};
    end
  end

  // Pipeline advance: hold the pipeline stages and the input while the skid entry is occupied.
  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign s_tready = en;

  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: request registers; row quotient of the word index.
  kind_t       kind1;
  logic [15:0] idx1;
  logic [15:0] data1;
  logic [33:0] q1_prod;

  assign q1_prod = {20'd0, idx1[15:2]} * {14'd0, recip};

  // Stage 2: quotient q1 = output row; split into source row and word column.
  kind_t       kind2;
  logic [15:0] idx2;
  logic [15:0] data2;
  logic [13:0] q1;
  logic        oor2;
  logic [33:0] sr_prod;
  logic [13:0] q1_f;
  logic [13:0] rem1;

  assign sr_prod = {20'd0, q1} * {14'd0, recip};
  assign q1_f    = 14'(q1 * {9'd0, f_sat});
  assign rem1    = idx2[15:2] - q1_f;

  // Stage 3: first output column of the word and its source column.
  kind_t       kind3;
  logic [15:0] idx3;
  logic [15:0] data3;
  logic        oor3;
  logic [5:0]  sr3;
  logic [9:0]  c0_3;
  logic [29:0] sc_prod;

  assign sc_prod = {20'd0, c0_3} * {10'd0, recip};

  // Stage 4: remainder within the source column; RAM read and load write.
  kind_t       kind4;
  logic [15:0] idx4;
  logic [15:0] data4;
  logic        oor4;
  logic [5:0]  sr4;
  logic [9:0]  c0_4;
  logic [5:0]  sc0_4;
  logic [9:0]  sc0_f;
  logic [9:0]  rem0_full;

  assign sc0_f     = 10'({4'd0, sc0_4} * {5'd0, f_sat});
  assign rem0_full = c0_4 - sc0_f;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [15:0]       word_a;
  logic [15:0]       word_b;

  // Loads land in the same stage that reads, so a later read always sees them.
  assign ram_wr_en = en && v4 && (kind4 == KIND_LOAD) && (idx4[15:ADDR_W] == '0);
  assign rd_addr_a = {sr4, sc0_4[5:4]};
  assign rd_addr_b = rd_addr_a + ADDR_W'(1);

  // Two copies so a word that straddles source words reads both in one cycle.
  ibu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SRC_WORDS)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx4[ADDR_W-1:0]),
    .wr_data (data4),
    .rd_en   (en),
    .rd_addr (rd_addr_a),
    .rd_data (word_a)
  );

  ibu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SRC_WORDS)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx4[ADDR_W-1:0]),
    .wr_data (data4),
    .rd_en   (en),
    .rd_addr (rd_addr_b),
    .rd_data (word_b)
  );

  // Stage 5: replicate source pixels into the output word.
  kind_t       kind5;
  logic        oor5;
  logic [3:0]  sc0_lo5;
  logic [3:0]  rem0_5;
  logic [15:0] pix_word;
  logic [31:0] pair;

  assign pair = {word_a, word_b};

  always_comb begin
    logic [4:0]  x;
    logic [24:0] dprod;
    logic [4:0]  col;
    pix_word = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      x        = {1'b0, rem0_5} + 5'(k);
      dprod    = {20'd0, x} * {5'd0, recip};
      col      = {1'b0, sc0_lo5} + dprod[23:19];
      pix_word[WORD_BITS-1-k] = pair[5'd31 - col];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1   <= kind_t'(s_tuser);
      idx1    <= s_tdata[15:0];
      data1   <= s_tdata[31:16];

      kind2   <= kind1;
      idx2    <= idx1;
      data2   <= data1;
      q1      <= q1_prod[32:19];
      oor2    <= ({1'b0, idx1} >= limit);

      kind3   <= kind2;
      idx3    <= idx2;
      data3   <= data2;
      oor3    <= oor2;
      sr3     <= sr_prod[24:19];
      c0_3    <= {rem1[3:0], idx2[1:0], 4'd0};

      kind4   <= kind3;
      idx4    <= idx3;
      data4   <= data3;
      oor4    <= oor3;
      sr4     <= sr3;
      c0_4    <= c0_3;
      sc0_4   <= sc_prod[24:19];

      kind5   <= kind4;
      oor5    <= oor4;
      sc0_lo5 <= sc0_4[3:0];
      rem0_5  <= rem0_full[3:0];
    end
  end

  // Output stage: main register plus one skid entry.
  logic        res_v;
  logic [15:0] res_word;
  logic [15:0] skid_word;
  logic        skid_oor;

  assign res_v    = en && v5 && (kind5 == KIND_READ);
  assign res_word = oor5 ? 16'd0 : pix_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      // Receiver stalls: park a new result in the skid entry.
      if (res_v) begin
        skid_v    <= 1'b1;
        skid_word <= res_word;
        skid_oor  <= oor5;
      end
    end else if (skid_v) begin
      // Drain the skid entry first; the pipeline is held meanwhile.
      m_tvalid <= 1'b1;
      m_tdata  <= skid_word;
      m_tuser  <= skid_oor;
      skid_v   <= 1'b0;
    end else begin
      m_tvalid <= res_v;
      if (res_v) begin
        m_tdata <= res_word;
        m_tuser <= oor5;
      end
    end
  end

endmodule
